// ===== sv/scf_pkg.sv =====
// Package for the servo command framer: widths, byte codes, register reset values,
// register index codes and the item, result, configuration and job types.
// Used by every module of the block; depends on nothing.
package scf_pkg;

  localparam int unsigned PosW     = 16;
  localparam int unsigned ChanW    = 7;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PulseW   = 14;
  localparam int unsigned SpanW    = 8;
  localparam int unsigned DvdW     = 30;
  localparam int unsigned DivW     = 16;
  localparam int unsigned DivBits  = 6;
  localparam int unsigned DivSteps = DvdW / DivBits;
  localparam int unsigned FrameMax = 6;
  localparam int unsigned CntW     = $clog2(FrameMax + 1);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [PosW-1:0] InputMaxDef = 16'd1023;
  localparam logic [PosW-1:0] InputMinDef = 16'd0;

  localparam logic [ByteW-1:0] SyncBin  = 8'h80;
  localparam logic [ByteW-1:0] CmdPos   = 8'h04;
  localparam logic [ByteW-1:0] CmdEn    = 8'h00;
  localparam logic [ByteW-1:0] EnOn     = 8'h7F;
  localparam logic [ByteW-1:0] EnOff    = 8'h00;
  localparam logic [ByteW-1:0] SyncMini = 8'hFF;
  localparam logic [ByteW-1:0] SatByte  = 8'hFF;
  localparam logic [ByteW-1:0] ChanOfs  = 8'd8;

  localparam logic             RstProtocol  = 1'b0;
  localparam logic [6:0]       RstDeviceId  = 7'd1;
  localparam logic [PulseW-1:0] RstPulseLow  = 14'd500;
  localparam logic [PulseW-1:0] RstPulseHigh = 14'd5500;
  localparam logic [SpanW-1:0] RstMiniSpan  = 8'd254;
  localparam logic [PosW-1:0]  RstBandLow   = 16'd256;
  localparam logic [PosW-1:0]  RstBandHigh  = 16'd767;

  typedef enum logic [2:0] {
    RegProtocol  = 3'd0,
    RegDeviceId  = 3'd1,
    RegPulseLow  = 3'd2,
    RegPulseHigh = 3'd3,
    RegMiniSpan  = 3'd4,
    RegBandLow   = 3'd5,
    RegBandHigh  = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    JobBinPos = 2'd0,
    JobBinEn  = 2'd1,
    JobMini   = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic             action;
    logic [ChanW-1:0] channel;
    logic [PosW-1:0]  position;
    logic             enable_on;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic              protocol_select;
    logic [6:0]        device_id;
    logic [PulseW-1:0] pulse_low;
    logic [PulseW-1:0] pulse_high;
    logic [SpanW-1:0]  mini_span;
    logic [PosW-1:0]   band_low;
    logic [PosW-1:0]   band_high;
  } cfg_t;

  typedef struct packed {
    job_kind_e         kind;
    logic [ByteW-1:0]  chan_byte;
    logic [6:0]        dev_id;
    logic              en_on;
    logic              neg;
    logic              sat;
    logic [PulseW-1:0] offset;
    logic [DivW-1:0]   divisor;
    logic [DvdW-1:0]   dividend;
  } job_t;

endpackage

// ===== sv/servo_command_framer.sv =====
// Top level of the servo command framer: configuration registers on an APB-style
// port, and the front end, job queue and back end. Depends on scf_pkg,
// scf_front, scf_queue and scf_back.
//
// Usage:
//   Commands enter on cmd_i with push/full: an item is taken at a clock edge
//   with push high and full low. Set-position commands out of the input range,
//   and set-enable commands in the mini protocol, are taken and send nothing.
//   Frame bytes leave on rsp_o with empty/pop, oldest first; rsp_o.last marks
//   the final byte of each frame.
//   Path: a byte-producing item passes the queue, the divider and the frame
//   load before its first byte shows; a set-enable item skips the divider.
//   The divider yields 6 quotient bits per cycle and can start the next job as
//   a frame loads; with pop held high a six-byte frame follows the previous one
//   without a gap. Commands are taken each cycle while the two-entry job queue
//   has room.
//   When the receiver stalls, the current byte holds, the divider finishes
//   the next job and waits, and full rises once the queue fills.
//   Reset empties the queue and the output and loads the register defaults.
//   Registers sit at byte address 4*i; write them only while the block is idle.
module servo_command_framer #(
  parameter logic [15:0] INPUT_MAX = scf_pkg::InputMaxDef,
  parameter logic [15:0] INPUT_MIN = scf_pkg::InputMinDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scf_pkg::AddrW-1:0]   paddr,
  input  logic [scf_pkg::DataW-1:0]   pwdata,
  output logic [scf_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  scf_pkg::cmd_t               cmd_i,
  input  logic                        push,
  output logic                        full,
  output scf_pkg::rsp_t               rsp_o,
  output logic                        empty,
  input  logic                        pop
);
  import scf_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;
  logic     accept;
  logic     enq;
  job_t     enq_job;
  job_t     q_job;
  logic     q_valid;
  logic     q_pop;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_select <= RstProtocol;
      cfg_q.device_id       <= RstDeviceId;
      cfg_q.pulse_low       <= RstPulseLow;
      cfg_q.pulse_high      <= RstPulseHigh;
      cfg_q.mini_span       <= RstMiniSpan;
      cfg_q.band_low        <= RstBandLow;
      cfg_q.band_high       <= RstBandHigh;
    end else if (wr_en) begin
      case (reg_idx)
        RegProtocol:  cfg_q.protocol_select <= pwdata[0];
        RegDeviceId:  cfg_q.device_id       <= pwdata[6:0];
        RegPulseLow:  cfg_q.pulse_low       <= pwdata[PulseW-1:0];
        RegPulseHigh: cfg_q.pulse_high      <= pwdata[PulseW-1:0];
        RegMiniSpan:  cfg_q.mini_span       <= pwdata[SpanW-1:0];
        RegBandLow:   cfg_q.band_low        <= pwdata[PosW-1:0];
        RegBandHigh:  cfg_q.band_high       <= pwdata[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegProtocol:  prdata = DataW'(cfg_q.protocol_select);
      RegDeviceId:  prdata = DataW'(cfg_q.device_id);
      RegPulseLow:  prdata = DataW'(cfg_q.pulse_low);
      RegPulseHigh: prdata = DataW'(cfg_q.pulse_high);
      RegMiniSpan:  prdata = DataW'(cfg_q.mini_span);
      RegBandLow:   prdata = DataW'(cfg_q.band_low);
      RegBandHigh:  prdata = DataW'(cfg_q.band_high);
      default:      prdata = '0;
    endcase
  end

  assign accept = push && !full;

  scf_front #(
    .INPUT_MAX (INPUT_MAX),
    .INPUT_MIN (INPUT_MIN)
  ) u_front (
    .cfg_i    (cfg_q),
    .cmd_i    (cmd_i),
    .accept_i (accept),
    .enq_o    (enq),
    .job_o    (enq_job)
  );

  scf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .data_i  (enq_job),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_job),
    .valid_o (q_valid)
  );

  scf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_job_i   (q_job),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

endmodule

// ===== sv/scf_front.sv =====
// Front end: classifies an accepted command, drops the ones that send nothing,
// and forms the job (frame kind, product, divisor). Depends on scf_pkg.
module scf_front #(
  parameter logic [15:0] INPUT_MAX = scf_pkg::InputMaxDef,
  parameter logic [15:0] INPUT_MIN = scf_pkg::InputMinDef
) (
  input  scf_pkg::cfg_t cfg_i,
  input  scf_pkg::cmd_t cmd_i,
  input  logic          accept_i,
  output logic          enq_o,
  output scf_pkg::job_t job_o
);
  import scf_pkg::*;

  logic              in_range;
  logic              in_band;
  logic              neg;
  logic [PulseW-1:0] diff_mag;
  logic [PosW-1:0]   mul_a;
  logic [PulseW-1:0] mul_b;
  logic              keep;

  assign in_range = (cmd_i.position <= INPUT_MAX) && (cmd_i.position >= INPUT_MIN);
  assign in_band  = (cmd_i.position >= cfg_i.band_low) && (cmd_i.position <= cfg_i.band_high);
  assign neg      = cfg_i.pulse_high < cfg_i.pulse_low;
  assign diff_mag = neg ? (cfg_i.pulse_low - cfg_i.pulse_high)
                        : (cfg_i.pulse_high - cfg_i.pulse_low);

  always_comb begin
    keep          = 1'b0;
    mul_a         = cmd_i.position;
    mul_b         = diff_mag;
    job_o.kind    = JobBinPos;
    job_o.chan_byte = {1'b0, cmd_i.channel};
    job_o.dev_id  = cfg_i.device_id;
    job_o.en_on   = cmd_i.enable_on;
    job_o.neg     = neg;
    job_o.sat     = 1'b0;
    job_o.offset  = cfg_i.pulse_low;
    job_o.divisor = INPUT_MAX;
    if (cmd_i.action) begin
      job_o.kind = JobBinEn;
      keep       = !cfg_i.protocol_select;
    end else if (in_range) begin
      keep = 1'b1;
      if (cfg_i.protocol_select) begin
        job_o.kind = JobMini;
        mul_b      = {{(PulseW-SpanW){1'b0}}, cfg_i.mini_span};
        if (in_band) begin
          mul_a         = cmd_i.position - cfg_i.band_low;
          job_o.divisor = cfg_i.band_high - cfg_i.band_low;
          job_o.sat     = (cfg_i.band_high == cfg_i.band_low);
        end else begin
          job_o.chan_byte = {1'b0, cmd_i.channel} + ChanOfs;
        end
      end
    end
    job_o.dividend = DvdW'(mul_a) * DvdW'(mul_b);
  end

  assign enq_o = accept_i && keep;

endmodule

// ===== sv/scf_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on scf_pkg for the job type and depth.
module scf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  scf_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output scf_pkg::job_t data_o,
  output logic          valid_o
);
  import scf_pkg::*;

  localparam int unsigned PtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  job_t             mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/scf_divider.sv =====
// Iterative unsigned divider, several quotient bits per cycle.
// Depends on scf_pkg for the operand widths and step counts.
module scf_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [scf_pkg::DvdW-1:0]    dividend_i,
  input  logic [scf_pkg::DivW-1:0]    divisor_i,
  output logic                        busy_o,
  output logic [scf_pkg::DvdW-1:0]    quotient_o
);
  import scf_pkg::*;

  localparam int unsigned StepCntW = $clog2(DivSteps + 1);

  logic [DivW-1:0]     rem_q, rem_d;
  logic [DvdW-1:0]     quo_q, quo_d;
  logic [DivW-1:0]     div_q;
  logic [StepCntW-1:0] cnt_q;

  always_comb begin
    logic [DivW:0] t;
    rem_d = rem_q;
    quo_d = quo_q;
    t     = '0;
    for (int k = 0; k < DivBits; k++) begin
      t     = {rem_d, quo_d[DvdW-1]};
      quo_d = {quo_d[DvdW-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t        = t - {1'b0, div_q};
        quo_d[0] = 1'b1;
      end
      rem_d = t[DivW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_o) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= StepCntW'(DivSteps);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

// ===== sv/scf_back.sv =====
// Back end: takes jobs from the queue, runs the divider, builds the frame and
// shifts it out one byte per result item. Depends on scf_pkg and scf_divider.
module scf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scf_pkg::job_t q_job_i,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  output scf_pkg::rsp_t rsp_o,
  output logic          empty_o,
  input  logic          pop_i
);
  import scf_pkg::*;

  logic             d_valid_q;
  job_t             d_job_q;
  logic             div_start;
  logic             div_busy;
  logic [DvdW-1:0]  quo;
  logic             d_done;
  logic             s_free;
  logic             s_load;
  logic [CntW-1:0]  s_cnt_q;
  logic [ByteW-1:0] s_bytes_q [FrameMax];
  logic [ByteW-1:0] frame [FrameMax];
  logic [CntW-1:0]  frame_len;
  logic [PulseW-1:0] q_signed;
  logic [PulseW-1:0] q_pos;

  scf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (q_job_i.dividend),
    .divisor_i  (q_job_i.divisor),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign d_done    = d_valid_q && !div_busy;
  assign s_free    = (s_cnt_q == '0) || (pop_i && (s_cnt_q == CntW'(1)));
  assign s_load    = d_done && s_free;
  assign q_pop_o   = q_valid_i && (!d_valid_q || s_load);
  assign div_start = q_pop_o && (q_job_i.kind != JobBinEn);

  assign q_signed = d_job_q.neg ? (PulseW'(0) - quo[PulseW-1:0]) : quo[PulseW-1:0];
  assign q_pos    = d_job_q.offset + q_signed;

  always_comb begin
    for (int k = 0; k < FrameMax; k++) begin
      frame[k] = '0;
    end
    frame_len = CntW'(3);
    case (d_job_q.kind)
      JobBinPos: begin
        frame[0]  = SyncBin;
        frame[1]  = {1'b0, d_job_q.dev_id};
        frame[2]  = CmdPos;
        frame[3]  = d_job_q.chan_byte;
        frame[4]  = {1'b0, q_pos[13:7]};
        frame[5]  = {1'b0, q_pos[6:0]};
        frame_len = CntW'(6);
      end
      JobBinEn: begin
        frame[0]  = SyncBin;
        frame[1]  = {1'b0, d_job_q.dev_id};
        frame[2]  = CmdEn;
        frame[3]  = d_job_q.chan_byte;
        frame[4]  = d_job_q.en_on ? EnOn : EnOff;
        frame_len = CntW'(5);
      end
      default: begin
        frame[0]  = SyncMini;
        frame[1]  = d_job_q.chan_byte;
        frame[2]  = d_job_q.sat ? SatByte : quo[ByteW-1:0];
        frame_len = CntW'(3);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      d_job_q <= q_job_i;
    end
    if (s_load) begin
      for (int k = 0; k < FrameMax; k++) begin
        s_bytes_q[k] <= frame[k];
      end
    end else if (pop_i && !empty_o) begin
      for (int k = 0; k < FrameMax - 1; k++) begin
        s_bytes_q[k] <= s_bytes_q[k+1];
      end
      s_bytes_q[FrameMax-1] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      s_cnt_q   <= '0;
    end else begin
      if (q_pop_o) begin
        d_valid_q <= 1'b1;
      end else if (s_load) begin
        d_valid_q <= 1'b0;
      end
      if (s_load) begin
        s_cnt_q <= frame_len;
      end else if (pop_i && !empty_o) begin
        s_cnt_q <= s_cnt_q - 1'b1;
      end
    end
  end

  assign empty_o        = (s_cnt_q == '0);
  assign rsp_o.out_byte = s_bytes_q[0];
  assign rsp_o.last     = (s_cnt_q == CntW'(1));

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_cnt_q <= CntW'(FrameMax))
    else $error("frame byte count above frame size");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_load |=> (s_cnt_q == CntW'(3) || s_cnt_q == CntW'(5) || s_cnt_q == CntW'(6)))
    else $error("loaded frame has a bad length");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && (s_cnt_q == CntW'(1)) && !s_load) |=> empty_o)
    else $error("output not empty after last byte");

endmodule

// ===== dv/scf_test_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes for the servo command framer testbench: command and protocol
// codes, frame byte values and the input range. Depends on nothing.
package scf_test_pkg;

  typedef enum logic {
    ActSetPosition = 1'b0,
    ActSetEnable   = 1'b1
  } action_e;

  typedef enum logic {
    ProtoBinary = 1'b0,
    ProtoMini   = 1'b1
  } protocol_e;

  localparam logic [7:0] FrameSyncBin  = 8'h80;
  localparam logic [7:0] FrameSyncMini = 8'hFF;
  localparam logic [7:0] OpSetPos      = 8'h04;
  localparam logic [7:0] OpSetEnable   = 8'h00;
  localparam logic [7:0] EnableByteOn  = 8'h7F;
  localparam logic [7:0] EnableByteOff = 8'h00;
  localparam logic [7:0] MiniChanShift = 8'd8;
  localparam logic [7:0] FlatBandByte  = 8'hFF;

  localparam longint PosMax = 1023;
  localparam longint PosMin = 0;

endpackage

// ===== dv/servo_frame_checker.sv =====
`timescale 1ns / 1ps
// Frame checker for the servo command framer: follows register writes, predicts
// the frame bytes of each accepted command and compares them with popped bytes.
// Depends on scf_pkg and scf_test_pkg.
module servo_frame_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [scf_pkg::AddrW-1:0] paddr_i,
  input  logic [scf_pkg::DataW-1:0] pwdata_i,
  input  logic                      pready_i,
  input  scf_pkg::cmd_t             cmd_i,
  input  logic                      push_i,
  input  logic                      full_i,
  input  scf_pkg::rsp_t             rsp_i,
  input  logic                      empty_i,
  input  logic                      pop_i,
  output int                        fail_count_o,
  output int                        bytes_due_o
);
  import scf_pkg::*;
  import scf_test_pkg::*;

  cfg_t settings;
  rsp_t byte_q[$];
  rsp_t want;
  int   fails;

  function automatic void frame_command(cmd_t c);
    logic [7:0] frame[$];
    longint     slope;
    longint     scaled;
    logic [63:0] bits;
    longint     width;
    if (c.action == ActSetEnable) begin
      if (settings.protocol_select == ProtoMini) return;
      frame = '{FrameSyncBin, {1'b0, settings.device_id}, OpSetEnable, {1'b0, c.channel},
                c.enable_on ? EnableByteOn : EnableByteOff};
    end else begin
      if (longint'(c.position) > PosMax || longint'(c.position) < PosMin) return;
      if (settings.protocol_select == ProtoBinary) begin
        slope  = longint'(settings.pulse_high) - longint'(settings.pulse_low);
        scaled = longint'(c.position) * slope / PosMax + longint'(settings.pulse_low);
        bits   = scaled;
        frame  = '{FrameSyncBin, {1'b0, settings.device_id}, OpSetPos, {1'b0, c.channel},
                   {1'b0, bits[13:7]}, {1'b0, bits[6:0]}};
      end else if (c.position > settings.band_high || c.position < settings.band_low) begin
        bits  = longint'(c.position) * longint'(settings.mini_span) / PosMax;
        frame = '{FrameSyncMini, {1'b0, c.channel} + MiniChanShift, bits[7:0]};
      end else begin
        width = longint'(settings.band_high) - longint'(settings.band_low);
        if (width == 0) begin
          bits = FlatBandByte;
        end else begin
          bits = (longint'(c.position) - longint'(settings.band_low))
                 * longint'(settings.mini_span) / width;
        end
        frame = '{FrameSyncMini, {1'b0, c.channel}, bits[7:0]};
      end
    end
    foreach (frame[k]) byte_q.push_back('{out_byte: frame[k], last: k == frame.size() - 1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings = '{protocol_select: ProtoBinary, device_id: 7'd1, pulse_low: 14'd500,
                   pulse_high: 14'd5500, mini_span: 8'd254, band_low: 16'd256,
                   band_high: 16'd767};
      byte_q.delete();
      fails = 0;
      fail_count_o <= 0;
      bytes_due_o  <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrW-1:2])
          RegProtocol:  settings.protocol_select = pwdata_i[0];
          RegDeviceId:  settings.device_id       = pwdata_i[6:0];
          RegPulseLow:  settings.pulse_low       = pwdata_i[PulseW-1:0];
          RegPulseHigh: settings.pulse_high      = pwdata_i[PulseW-1:0];
          RegMiniSpan:  settings.mini_span       = pwdata_i[SpanW-1:0];
          RegBandLow:   settings.band_low        = pwdata_i[PosW-1:0];
          RegBandHigh:  settings.band_high       = pwdata_i[PosW-1:0];
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        if (byte_q.size() == 0) begin
          $error("out_byte: expected none, actual %h", rsp_i.out_byte);
          fails++;
        end else begin
          want = byte_q.pop_front();
          if (rsp_i.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, rsp_i.out_byte);
            fails++;
          end
          if (rsp_i.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, rsp_i.last);
            fails++;
          end
        end
      end
      if (push_i && !full_i) frame_command(cmd_i);
      fail_count_o <= fails;
      bytes_due_o  <= byte_q.size();
    end
  end

endmodule

// ===== dv/servo_command_framer_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the servo command framer: clock, reset, register writes,
// directed and random commands, receiver stalls and the verdict.
// Depends on scf_pkg, scf_test_pkg, servo_frame_checker and servo_command_framer.
module servo_command_framer_test;
  import scf_pkg::*;
  import scf_test_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  cmd_t             cmd;
  logic             push;
  logic             full;
  rsp_t             rsp;
  logic             empty;
  logic             pop;
  logic             quiet;
  int               fail_count;
  int               bytes_due;
  logic [15:0]      band_lo;
  logic [15:0]      band_hi;

  servo_command_framer #(
    .INPUT_MAX(16'(PosMax)),
    .INPUT_MIN(16'(PosMin))
  ) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cmd_i(cmd), .push, .full,
    .rsp_o(rsp), .empty, .pop
  );

  servo_frame_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .cmd_i(cmd), .push_i(push), .full_i(full),
    .rsp_i(rsp), .empty_i(empty), .pop_i(pop),
    .fail_count_o(fail_count), .bytes_due_o(bytes_due)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int stall;
    stall = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) stall = 0;
      else if (stall == 0 && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 9);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic cmd_t make_cmd(action_e act, int chan, int pos, bit en);
    cmd_t c;
    c.action    = act;
    c.channel   = chan[6:0];
    c.position  = pos[15:0];
    c.enable_on = en;
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd  <= c;
    push <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  task automatic send_pos(input int chan, input int pos);
    send_cmd(make_cmd(ActSetPosition, chan, pos, 1'($urandom_range(0, 1))));
  endtask

  task automatic write_reg(input reg_idx_e idx, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= DataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_band(input int lo, input int hi);
    band_lo = lo[15:0];
    band_hi = hi[15:0];
    write_reg(RegBandLow, lo);
    write_reg(RegBandHigh, hi);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic int pick_extreme(int top);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  task automatic shuffle_settings(input protocol_e proto);
    int lo;
    write_reg(RegProtocol, int'(proto));
    write_reg(RegDeviceId, pick_extreme(127));
    write_reg(RegPulseLow, pick_extreme(16383));
    write_reg(RegPulseHigh, pick_extreme(16383));
    write_reg(RegMiniSpan, pick_extreme(255));
    case ($urandom_range(0, 4))
      0: begin
        lo = $urandom_range(0, 1023);
        set_band(lo, $urandom_range(lo, 1023));
      end
      1: begin
        lo = $urandom_range(0, 1023);
        set_band(lo, lo);
      end
      2: begin
        lo = $urandom_range(1, 1023);
        set_band(lo, $urandom_range(0, lo - 1));
      end
      3: set_band(0, 65535);
      default: set_band($urandom_range(0, 65535), $urandom_range(0, 65535));
    endcase
  endtask

  function automatic int pick_position();
    case ($urandom_range(0, 9))
      6: return $urandom_range(0, 65535);
      7: begin
        case ($urandom_range(0, 3))
          0:       return 0;
          1:       return int'(PosMax);
          2:       return int'(PosMax + 1);
          default: return 65535;
        endcase
      end
      8: return $urandom_range(0, 1) ? int'(band_lo) : int'(band_lo - 16'd1);
      9: return $urandom_range(0, 1) ? int'(band_hi) : int'(band_hi + 16'd1);
      default: return $urandom_range(0, PosMax);
    endcase
  endfunction

  initial begin
    int act;
    quiet   = 1'b0;
    band_lo = 16'd256;
    band_hi = 16'd767;
    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cmd     <= '0;
    push    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    send_pos(0, 0);
    send_pos(127, int'(PosMax));
    send_pos(5, int'(PosMax + 1));
    send_pos(64, 65535);
    send_cmd(make_cmd(ActSetPosition, 85, 512, 1'b1));
    send_cmd(make_cmd(ActSetEnable, 127, 65535, 1'b1));
    send_cmd(make_cmd(ActSetEnable, 0, 0, 1'b0));
    drain();

    write_reg(RegPulseLow, 16383);
    write_reg(RegPulseHigh, 0);
    write_reg(RegDeviceId, 127);
    send_pos(42, 0);
    send_pos(42, int'(PosMax));
    send_pos(42, 341);
    drain();

    write_reg(RegPulseLow, 0);
    write_reg(RegPulseHigh, 16383);
    write_reg(RegDeviceId, 0);
    send_pos(1, int'(PosMax));
    send_pos(1, 1);
    drain();

    write_reg(RegProtocol, int'(ProtoMini));
    send_pos(3, 255);
    send_pos(3, 256);
    send_pos(3, 767);
    send_pos(3, 768);
    send_pos(127, int'(PosMax));
    send_cmd(make_cmd(ActSetEnable, 9, 300, 1'b1));
    send_pos(3, 2000);
    drain();

    write_reg(RegMiniSpan, 255);
    set_band(500, 500);
    send_pos(20, 500);
    send_pos(20, 499);
    send_pos(20, 501);
    drain();

    write_reg(RegMiniSpan, 0);
    set_band(800, 100);
    send_pos(7, 400);
    send_pos(7, 900);
    drain();

    write_reg(RegMiniSpan, 255);
    set_band(0, 65535);
    send_pos(120, int'(PosMax));
    send_pos(120, 0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      shuffle_settings(phase[0] ? ProtoMini : ProtoBinary);
      if (phase == 5) quiet = 1'b1;
      for (int n = 0; n < 34; n++) begin
        act = $urandom_range(0, 3);
        send_cmd(make_cmd(act == 0 ? ActSetEnable : ActSetPosition, $urandom_range(0, 127),
                          pick_position(), 1'($urandom_range(0, 1))));
      end
      drain();
    end

    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
